/* src/bict_pkg.sv */
// bict_pkg: request/status codes and word types for the bitmap-indexed table.
// No dependencies; used by the top level, bict_check and the benches under verif.
`default_nettype none

package bict_pkg;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_REFUSED = 2'd1,
    ST_ABSENT  = 2'd2
  } status_e;

  typedef logic [6:0]  slot_t;
  typedef logic [31:0] value_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] type_index;
    value_t     entry_value;
  } in_word_t;

  typedef struct packed {
    logic    found;
    value_t  value_out;
    slot_t   slot_index;
    status_e status;
    slot_t   entry_count;
  } out_word_t;

endpackage

`default_nettype wire

/* src/bict_ram.sv */
// bict_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bict_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/bict_rank.sv */
// bict_rank: presence test, rank below a type and total count over the mask.
// Depends on nothing; instantiated by bitmap_indexed_compact_table.
`default_nettype none

module bict_rank #(
  parameter int NUM_TYPES = 64
) (
  input  wire logic [NUM_TYPES-1:0]           mask,
  input  wire logic [5:0]                     type_index,
  output      logic                           present,
  output      logic [$clog2(NUM_TYPES+1)-1:0] rank,
  output      logic [$clog2(NUM_TYPES+1)-1:0] count
);

  localparam int CNT_W = $clog2(NUM_TYPES + 1);
  localparam int GRP   = (NUM_TYPES + 7) / 8;
  localparam int PAD   = GRP * 8;

  logic [PAD-1:0] mask_pad;
  logic [PAD-1:0] below_pad;
  logic [PAD-1:0] sel_pad;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  always_comb begin
    mask_pad  = '0;
    below_pad = '0;
    sel_pad   = '0;
    mask_pad[NUM_TYPES-1:0] = mask;
    for (int j = 0; j < NUM_TYPES; j++) begin
      below_pad[j] = 7'(j) < {1'b0, type_index};
      sel_pad[j]   = 7'(j) == {1'b0, type_index};
    end
  end

  assign present = |(mask_pad & sel_pad);

  always_comb begin
    logic [PAD-1:0] ranked;
    ranked = mask_pad & below_pad;
    rank   = '0;
    count  = '0;
    for (int g = 0; g < GRP; g++) begin
      rank  = rank + CNT_W'(pop8(ranked[g*8 +: 8]));
      count = count + CNT_W'(pop8(mask_pad[g*8 +: 8]));
    end
  end

endmodule

`default_nettype wire

/* src/bitmap_indexed_compact_table.sv */
// bitmap_indexed_compact_table: top level, presence mask, request decode and
// result register. Depends on bict_pkg, bict_rank and bict_ram.
//
//   channel  signals                       word
//   in       in_valid / in_ready           bict_pkg::in_word_t
//   out      out_valid / out_ready         bict_pkg::out_word_t
//
// One request per cycle unless a waiting result is stalled; its result shows in the cycle after acceptance.
// Rank and count come from the mask register in the same cycle; identifiers
// sit in a RAM addressed by type, written on add, read on lookup.
// Reset clears the mask and output valid; RAM contents stay undefined.
// A stalled result holds; in_ready follows out_ready while a result waits.
`default_nettype none

module bitmap_indexed_compact_table #(
  parameter int NUM_TYPES  = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire bict_pkg::in_word_t   in_data,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      bict_pkg::out_word_t  out_data
);

  localparam int CNT_W = $clog2(NUM_TYPES + 1);
  localparam int AW    = $clog2(NUM_TYPES);
  localparam int VW    = (VALUE_BITS < 32) ? VALUE_BITS : 32;

  logic [NUM_TYPES-1:0] mask_r, mask_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 found_r, hit_r;
  logic [CNT_W-1:0]     rank_r, count_r;
  bict_pkg::status_e    status_r;

  logic                 accept;
  logic                 in_range;
  logic                 present;
  logic [CNT_W-1:0]     rank, count, count_nxt;
  bict_pkg::status_e    status;
  logic                 do_add, do_rem, do_hit;
  logic [AW-1:0]        addr;
  logic [VW-1:0]        rdata;
  logic [NUM_TYPES-1:0] onehot;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign in_range = {1'b0, in_data.type_index} < 7'(NUM_TYPES);
  assign addr     = in_data.type_index[AW-1:0];

  bict_rank #(.NUM_TYPES(NUM_TYPES)) u_rank (
    .mask       (mask_r),
    .type_index (in_data.type_index),
    .present    (present),
    .rank       (rank),
    .count      (count)
  );

  always_comb begin
    do_add    = 1'b0;
    do_rem    = 1'b0;
    do_hit    = 1'b0;
    count_nxt = count;
    status    = present ? bict_pkg::ST_DONE : bict_pkg::ST_ABSENT;
    case (in_data.req_type)
      bict_pkg::REQ_ADD: begin
        if (!in_range) begin
          status = bict_pkg::ST_ABSENT;
        end else if (present) begin
          status = bict_pkg::ST_REFUSED;
        end else begin
          do_add    = 1'b1;
          count_nxt = count + CNT_W'(1);
          status    = bict_pkg::ST_DONE;
        end
      end
      bict_pkg::REQ_REMOVE: begin
        if (present) begin
          do_rem    = 1'b1;
          count_nxt = count - CNT_W'(1);
        end
      end
      default: begin
        do_hit = present;
      end
    endcase
  end

  always_comb begin
    for (int j = 0; j < NUM_TYPES; j++) begin
      onehot[j] = 7'(j) == {1'b0, in_data.type_index};
    end
    mask_nxt = mask_r;
    if (accept && do_add) begin
      mask_nxt = mask_r | onehot;
    end else if (accept && do_rem) begin
      mask_nxt = mask_r & ~onehot;
    end
    out_valid_nxt = accept || (out_valid_r && !out_ready);
  end

  bict_ram #(.WIDTH(VW), .DEPTH(NUM_TYPES)) u_ram (
    .clk   (clk),
    .we    (accept && do_add),
    .waddr (addr),
    .wdata (in_data.entry_value[VW-1:0]),
    .re    (accept && do_hit),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      found_r  <= present;
      hit_r    <= do_hit;
      rank_r   <= rank;
      count_r  <= count_nxt;
      status_r <= status;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_data.found        = found_r;
  assign out_data.value_out    = hit_r ? bict_pkg::value_t'(rdata) : '0;
  assign out_data.slot_index   = bict_pkg::slot_t'(rank_r);
  assign out_data.status       = status_r;
  assign out_data.entry_count  = bict_pkg::slot_t'(count_r);

endmodule

`default_nettype wire

/* src/bict_check.sv */
// bict_check: port-level checks for bitmap_indexed_compact_table, bound in.
// Depends on bict_pkg.
`default_nettype none

module bict_check (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire bict_pkg::in_word_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire bict_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

  a_refused_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == bict_pkg::ST_REFUSED |-> out_data.found)
    else $error("refused add without a present type");

  a_value_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.value_out != '0 |->
      out_data.found && out_data.status == bict_pkg::ST_DONE)
    else $error("value on a result that is not a hit");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.entry_count <= 7'd64 && out_data.slot_index <= 7'd64)
    else $error("count or slot out of range");

endmodule

bind bitmap_indexed_compact_table bict_check u_check (.*);

`default_nettype wire

/* verif/bict_table_checker.sv */
// bict_table_checker: watches both channels of bitmap_indexed_compact_table,
// predicts each result word from its own copy of the table, and counts faults.
// Depends on bict_pkg.
module bict_table_checker
  import bict_pkg::*;
#(
  parameter int NUM_TYPES  = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_data,
  output int        outstanding,
  output int        fault_count,
  output int        words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] TYPE_MASK = {64{1'b1}} >> (64 - NUM_TYPES);
  localparam value_t VALUE_MASK = (VALUE_BITS >= 32) ? '1 :
                                  value_t'((64'd1 << VALUE_BITS) - 64'd1);

  logic [63:0] table_mask;
  value_t      table_vals [64];
  out_word_t   expected_words [$];

  initial begin
    outstanding   = 0;
    fault_count   = 0;
    words_checked = 0;
    table_mask    = '0;
  end

  // Applies one request to the shadow table and returns the result word.
  function automatic out_word_t table_apply(in_word_t w);
    out_word_t   r;
    logic [63:0] below;
    int          rank;
    int          count;
    int          t;
    int          i;
    bit          in_range;
    bit          hit;
    r        = '0;
    t        = int'(w.type_index);
    in_range = t < NUM_TYPES;
    below    = in_range ? ((64'd1 << t) - 64'd1) : TYPE_MASK;
    rank     = $countones(table_mask & below);
    count    = $countones(table_mask);
    hit      = in_range && table_mask[t];
    r.status = ST_ABSENT;
    case (w.req_type)
      REQ_ADD: begin
        if (hit) begin
          r.status = ST_REFUSED;
        end else if (in_range) begin
          for (i = 63; i > rank; i--) table_vals[i] = table_vals[i-1];
          table_vals[rank] = w.entry_value & VALUE_MASK;
          table_mask[t]    = 1'b1;
          count++;
          r.status = ST_DONE;
        end
      end
      REQ_REMOVE: begin
        if (hit) begin
          for (i = rank; i < 63; i++) table_vals[i] = table_vals[i+1];
          table_mask[t] = 1'b0;
          count--;
          r.status = ST_DONE;
        end
      end
      default: begin
        if (hit) begin
          r.value_out = table_vals[rank];
          r.status    = ST_DONE;
        end
      end
    endcase
    r.found       = hit;
    r.slot_index  = slot_t'(rank);
    r.entry_count = slot_t'(count);
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      table_mask = '0;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("checker: result word with nothing expected: %p", out_data);
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (out_data.found !== want.found || out_data.value_out !== want.value_out ||
              out_data.slot_index !== want.slot_index ||
              out_data.status !== want.status ||
              out_data.entry_count !== want.entry_count) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display({"checker: word %0d expected found=%0b value=%h slot=%0d",
                        " status=%0d count=%0d"},
                       words_checked, want.found, want.value_out, want.slot_index,
                       want.status, want.entry_count);
              $display({"checker: word %0d got      found=%0b value=%h slot=%0d",
                        " status=%0d count=%0d"},
                       words_checked, out_data.found, out_data.value_out,
                       out_data.slot_index, out_data.status, out_data.entry_count);
            end
          end
        end
      end
      if (in_valid && in_ready)
        expected_words.insert(expected_words.size(), table_apply(in_data));
    end
    outstanding <= expected_words.size();
  end

endmodule

/* verif/tb_bitmap_indexed_compact_table.sv */
// tb_bitmap_indexed_compact_table: drives requests and random back-pressure
// into the table, and gives the verdict. Depends on bict_pkg, the RTL under
// src and bict_table_checker.
module tb_bitmap_indexed_compact_table;
  import bict_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_SPARE = 2'd3;  // unused code, behaves as lookup
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_WORDS = 146;

  typedef enum int {MODE_FILL, MODE_MIXED, MODE_DRAIN} mode_e;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      out_ready = 1'b0;
  in_word_t  in_data   = '0;
  logic      in_ready;
  logic      out_valid;
  out_word_t out_data;

  int outstanding;
  int fault_count;
  int words_checked;

  bit          calm     = 1'b0;
  bit          gaps_on  = 1'b1;
  logic [63:0] occupied = '0;
  int n_lookup = 0, n_spare = 0, n_add = 0, n_remove = 0, peak = 0;
  int cycles = 0;

  bitmap_indexed_compact_table #(.NUM_TYPES(64), .VALUE_BITS(32)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  bict_table_checker #(.NUM_TYPES(64), .VALUE_BITS(32)) table_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .outstanding  (outstanding),
    .fault_count  (fault_count),
    .words_checked(words_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk) cycles++;
    $display("tb: failure");
    $finish;
  end

  // receiver: stall bursts mixed with long ready runs, none once calm
  initial begin
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  function automatic in_word_t mk(logic [1:0] req, int t, value_t v);
    in_word_t w;
    w.req_type    = req;
    w.type_index  = 6'(t);
    w.entry_value = v;
    return w;
  endfunction

  function automatic int pick_type(bit want_present);
    int start;
    int idx;
    start = $urandom_range(0, 63);
    for (int k = 0; k < 64; k++) begin
      idx = (start + k) % 64;
      if (occupied[idx] == want_present) return idx;
    end
    return start;
  endfunction

  function automatic in_word_t random_word(mode_e m);
    in_word_t w;
    int       roll;
    int       add_pct;
    int       rem_pct;
    bit       aim;
    case (m)
      MODE_FILL:  begin add_pct = 70; rem_pct = 10; end
      MODE_MIXED: begin add_pct = 35; rem_pct = 30; end
      default:    begin add_pct = 10; rem_pct = 70; end
    endcase
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0)
      w.entry_value = $urandom_range(0, 1) ? '1 : '0;
    else
      w.entry_value = value_t'($urandom);
    if (roll < add_pct) begin
      w.req_type = REQ_ADD;
      aim        = $urandom_range(0, 99) >= 85;
    end else if (roll < add_pct + rem_pct) begin
      w.req_type = REQ_REMOVE;
      aim        = $urandom_range(0, 99) < 85;
    end else begin
      w.req_type = ($urandom_range(0, 99) < 15) ? REQ_SPARE : REQ_LOOKUP;
      aim        = $urandom_range(0, 99) < 70;
    end
    w.type_index = 6'(pick_type(aim));
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    case (w.req_type)
      REQ_ADD: begin
        n_add++;
        occupied[w.type_index] = 1'b1;
      end
      REQ_REMOVE: begin
        n_remove++;
        occupied[w.type_index] = 1'b0;
      end
      REQ_LOOKUP: n_lookup++;
      default:    n_spare++;
    endcase
    if ($countones(occupied) > peak) peak = $countones(occupied);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_word(mk(REQ_LOOKUP, 0, '0));
    send_word(mk(REQ_REMOVE, 63, '1));
    send_word(mk(REQ_ADD, 63, '1));
    send_word(mk(REQ_ADD, 0, '0));
    send_word(mk(REQ_ADD, 0, 32'h0000_1234));
    send_word(mk(REQ_LOOKUP, 63, '0));
    send_word(mk(REQ_LOOKUP, 0, '1));
    send_word(mk(REQ_ADD, 31, 32'hA5A5_A5A5));
    send_word(mk(REQ_ADD, 32, 32'h5A5A_5A5A));
    send_word(mk(REQ_SPARE, 32, '0));
    send_word(mk(REQ_LOOKUP, 63, '0));
    send_word(mk(REQ_REMOVE, 31, '0));
    send_word(mk(REQ_LOOKUP, 32, '0));
    send_word(mk(REQ_REMOVE, 31, '0));
    send_word(mk(REQ_SPARE, 31, '0));
    send_word(mk(REQ_ADD, 21, 32'h8000_0001));
    send_word(mk(REQ_REMOVE, 0, '0));
    send_word(mk(REQ_LOOKUP, 21, '0));
    send_word(mk(REQ_LOOKUP, 63, '0));
    send_word(mk(REQ_REMOVE, 63, '0));
    send_word(mk(REQ_LOOKUP, 63, '0));
    drain_results();

    for (int p = 0; p < 6; p++) begin
      calm = (p == 5);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n % 40 == 0) gaps_on = $urandom_range(0, 2) != 0;
        send_word(random_word(mode_e'(p % 3)));
      end
      if (p == 1 || p == 3) drain_results();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);

    $display("tb summary: %0d lookups, %0d code-3 lookups, %0d adds, %0d removes; %0d results checked",
             n_lookup, n_spare, n_add, n_remove, words_checked);
    $display("tb summary: occupancy peaked at %0d of 64 types, %0d faults", peak, fault_count);
    if (fault_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* bitmap_indexed_compact_table.f */
src/bict_pkg.sv
src/bict_ram.sv
src/bict_rank.sv
src/bitmap_indexed_compact_table.sv
src/bict_check.sv
verif/bict_table_checker.sv
verif/tb_bitmap_indexed_compact_table.sv
